/* rtl/sawq_pkg.sv */
// Shared types, codes and constants of the stop-and-wait ARQ sender.
// No dependencies; the front end, back end, top level and testbench refer to this package.
package sawq_pkg;

  localparam int unsigned MaxSegBytes = 1024;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [19:0] TimeoutReset    = 20'd1000;
  localparam logic [3:0]  MaxRetriesReset = 4'd3;
  localparam logic [31:0] InitSeqReset    = 32'd0;

  // host action codes
  localparam logic [2:0] ActTick  = 3'd0;
  localparam logic [2:0] ActRx    = 3'd1;
  localparam logic [2:0] ActOpen  = 3'd2;
  localparam logic [2:0] ActSend  = 3'd3;
  localparam logic [2:0] ActClose = 3'd4;

  // status codes
  localparam logic [2:0] StNone      = 3'd0;
  localparam logic [2:0] StConnected = 3'd1;
  localparam logic [2:0] StAcked     = 3'd2;
  localparam logic [2:0] StClosed    = 3'd3;
  localparam logic [2:0] StFailed    = 3'd4;
  localparam logic [2:0] StRejected  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CfgTimeout    = 2'd0;
  localparam logic [1:0] CfgMaxRetries = 2'd1;
  localparam logic [1:0] CfgInitSeq    = 2'd2;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_TICK   = 3'd1,
    KIND_RX     = 3'd2,
    KIND_OPEN   = 3'd3,
    KIND_SEND   = 3'd4,
    KIND_CLOSE  = 3'd5,
    KIND_REJECT = 3'd6
  } kind_t;

  typedef enum logic [5:0] {
    PH_CLOSED    = 6'b000001,
    PH_SYN_SENT  = 6'b000010,
    PH_OPEN      = 6'b000100,
    PH_DATA_WAIT = 6'b001000,
    PH_FIN_SENT  = 6'b010000,
    PH_FIN_WAIT  = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic        rx_syn;
    logic        rx_ackflag;
    logic        rx_fin;
    logic [31:0] rx_sequence;
    logic [31:0] rx_ack_number;
    logic        rx_checksum_ok;
    logic [10:0] segment_length;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        tx_valid;
    logic        tx_syn;
    logic        tx_ackflag;
    logic        tx_fin;
    logic [31:0] tx_sequence;
    logic [31:0] tx_ack_number;
    logic [10:0] tx_length;
    logic [2:0]  status;
  } result_t;

endpackage

/* rtl/sawq_in_if.sv */
// Input channel of the ARQ sender: valid/ready handshake plus one event word.
// Depends on nothing.
interface sawq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        rx_syn;
  logic        rx_ackflag;
  logic        rx_fin;
  logic [31:0] rx_sequence;
  logic [31:0] rx_ack_number;
  logic        rx_checksum_ok;
  logic [10:0] segment_length;

  modport source (
    output valid, action, rx_syn, rx_ackflag, rx_fin, rx_sequence, rx_ack_number,
           rx_checksum_ok, segment_length,
    input  ready
  );
  modport sink (
    input  valid, action, rx_syn, rx_ackflag, rx_fin, rx_sequence, rx_ack_number,
           rx_checksum_ok, segment_length,
    output ready
  );
endinterface

/* rtl/sawq_out_if.sv */
// Result channel of the ARQ sender: valid/ready handshake plus one header/status word.
// Depends on nothing.
interface sawq_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic        tx_syn;
  logic        tx_ackflag;
  logic        tx_fin;
  logic [31:0] tx_sequence;
  logic [31:0] tx_ack_number;
  logic [10:0] tx_length;
  logic [2:0]  status;

  modport source (
    output valid, tx_valid, tx_syn, tx_ackflag, tx_fin, tx_sequence, tx_ack_number,
           tx_length, status,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_syn, tx_ackflag, tx_fin, tx_sequence, tx_ack_number,
           tx_length, status,
    output ready
  );
endinterface

/* rtl/sawq_front.sv */
// Front end: accepts event words, classifies them and queues them for the back end.
// Depends on sawq_pkg and sawq_in_if.
module sawq_front #(
  parameter int unsigned DEPTH = sawq_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  sawq_in_if.sink         in_chan,
  output sawq_pkg::head_t head,
  input  logic            pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sawq_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;
  sawq_pkg::item_t cls;

  always_comb begin
    cls.rx_syn         = in_chan.rx_syn;
    cls.rx_ackflag     = in_chan.rx_ackflag;
    cls.rx_fin         = in_chan.rx_fin;
    cls.rx_sequence    = in_chan.rx_sequence;
    cls.rx_ack_number  = in_chan.rx_ack_number;
    cls.rx_checksum_ok = in_chan.rx_checksum_ok;
    cls.segment_length = in_chan.segment_length;
    case (in_chan.action)
      sawq_pkg::ActTick:  cls.kind = sawq_pkg::KIND_TICK;
      sawq_pkg::ActRx:    cls.kind = sawq_pkg::KIND_RX;
      sawq_pkg::ActOpen:  cls.kind = sawq_pkg::KIND_OPEN;
      sawq_pkg::ActSend: begin
        // oversized segments are rejected in any phase
        if (32'(in_chan.segment_length) > sawq_pkg::MaxSegBytes) begin
          cls.kind = sawq_pkg::KIND_REJECT;
        end else begin
          cls.kind = sawq_pkg::KIND_SEND;
        end
      end
      sawq_pkg::ActClose: cls.kind = sawq_pkg::KIND_CLOSE;
      default:            cls.kind = sawq_pkg::KIND_NONE;
    endcase
  end

  assign in_chan.ready = (count_r != CW'(DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head.valid    = (count_r != '0);
  assign head.item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* rtl/sawq_back.sv */
// Back end: connection state machine, retransmit timer and registered result word.
// Depends on sawq_pkg and sawq_out_if.
module sawq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sawq_pkg::cfg_wr_t cfg,
  input  sawq_pkg::head_t   head,
  output logic              pop,
  sawq_out_if.source        out_chan
);

  sawq_pkg::phase_t  phase_r, phase_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic              hdr_syn_r, hdr_syn_nxt;
  logic              hdr_fin_r, hdr_fin_nxt;
  logic [31:0]       hdr_seq_r, hdr_seq_nxt;
  logic [10:0]       hdr_len_r, hdr_len_nxt;
  logic [31:0]       peer_r, peer_nxt;
  logic [19:0]       timer_r, timer_nxt;
  logic [3:0]        retry_r, retry_nxt;
  logic [19:0]       timeout_r, timeout_nxt;
  logic [3:0]        retry_cap_r, retry_cap_nxt;
  sawq_pkg::result_t out_r, res;
  logic              out_valid_r, out_valid_nxt;

  sawq_pkg::item_t   it;
  sawq_pkg::result_t resend;
  logic              acked;
  logic [31:0]       seq_inc;
  logic [19:0]       timer_inc;
  logic [3:0]        retry_inc;

  function automatic sawq_pkg::result_t mk_hdr(input logic syn, input logic fin,
                                               input logic [31:0] seq,
                                               input logic [10:0] len);
    sawq_pkg::result_t r;
    r               = '0;
    r.tx_valid      = 1'b1;
    r.tx_syn        = syn;
    r.tx_fin        = fin;
    r.tx_sequence   = seq;
    r.tx_ack_number = (!syn && !fin) ? seq - 32'd1 : 32'd0;
    r.tx_length     = len;
    return r;
  endfunction

  function automatic sawq_pkg::result_t mk_ack(input logic [31:0] seq,
                                               input logic [31:0] ackno);
    sawq_pkg::result_t r;
    r               = '0;
    r.tx_valid      = 1'b1;
    r.tx_ackflag    = 1'b1;
    r.tx_sequence   = seq;
    r.tx_ack_number = ackno;
    return r;
  endfunction

  assign it        = head.item;
  assign pop       = head.valid && (!out_valid_r || out_chan.ready);
  assign seq_inc   = seq_r + 32'd1;
  assign timer_inc = timer_r + 20'd1;
  assign retry_inc = retry_r + 4'd1;
  assign acked     = it.rx_ackflag && it.rx_checksum_ok &&
                     (it.rx_ack_number == hdr_seq_r + 32'd1);
  assign resend    = mk_hdr(hdr_syn_r, hdr_fin_r, hdr_seq_r, hdr_len_r);

  always_comb begin
    phase_nxt     = phase_r;
    seq_nxt       = seq_r;
    hdr_syn_nxt   = hdr_syn_r;
    hdr_fin_nxt   = hdr_fin_r;
    hdr_seq_nxt   = hdr_seq_r;
    hdr_len_nxt   = hdr_len_r;
    peer_nxt      = peer_r;
    timer_nxt     = timer_r;
    retry_nxt     = retry_r;
    timeout_nxt   = timeout_r;
    retry_cap_nxt = retry_cap_r;
    res           = '0;
    if (pop) begin
      case (it.kind)
        sawq_pkg::KIND_TICK: begin
          if (phase_r inside {sawq_pkg::PH_SYN_SENT, sawq_pkg::PH_DATA_WAIT,
                              sawq_pkg::PH_FIN_SENT}) begin
            timer_nxt = timer_inc;
            if (timer_inc >= timeout_r) begin
              timer_nxt = '0;
              if (phase_r == sawq_pkg::PH_SYN_SENT) begin
                retry_nxt = retry_inc;
                if (retry_inc >= retry_cap_r) begin
                  phase_nxt  = sawq_pkg::PH_CLOSED;
                  res.status = sawq_pkg::StFailed;
                end else begin
                  res = resend;
                end
              end else begin
                res = resend;
              end
            end
          end
        end
        sawq_pkg::KIND_RX: begin
          case (phase_r)
            sawq_pkg::PH_SYN_SENT: begin
              if (it.rx_syn && acked) begin
                seq_nxt    = seq_inc;
                peer_nxt   = it.rx_sequence;
                res        = mk_ack(seq_inc, it.rx_sequence + 32'd1);
                res.status = sawq_pkg::StConnected;
                phase_nxt  = sawq_pkg::PH_OPEN;
              end else begin
                timer_nxt = '0;
                res       = resend;
              end
            end
            sawq_pkg::PH_DATA_WAIT: begin
              if (acked) begin
                phase_nxt  = sawq_pkg::PH_OPEN;
                res.status = sawq_pkg::StAcked;
              end else begin
                phase_nxt  = sawq_pkg::PH_CLOSED;
                res.status = sawq_pkg::StFailed;
              end
            end
            sawq_pkg::PH_FIN_SENT: begin
              if (acked) begin
                peer_nxt  = it.rx_sequence;
                phase_nxt = sawq_pkg::PH_FIN_WAIT;
              end else begin
                phase_nxt  = sawq_pkg::PH_CLOSED;
                res.status = sawq_pkg::StFailed;
              end
            end
            sawq_pkg::PH_FIN_WAIT: begin
              if (it.rx_fin && it.rx_checksum_ok &&
                  (it.rx_sequence == peer_r + 32'd1)) begin
                seq_nxt    = seq_inc;
                res        = mk_ack(seq_inc, it.rx_sequence + 32'd1);
                res.status = sawq_pkg::StClosed;
              end else begin
                res.status = sawq_pkg::StFailed;
              end
              phase_nxt = sawq_pkg::PH_CLOSED;
            end
            default: ;
          endcase
        end
        sawq_pkg::KIND_OPEN, sawq_pkg::KIND_SEND, sawq_pkg::KIND_CLOSE: begin
          if ((it.kind == sawq_pkg::KIND_OPEN && phase_r == sawq_pkg::PH_CLOSED) ||
              (it.kind != sawq_pkg::KIND_OPEN && phase_r == sawq_pkg::PH_OPEN)) begin
            seq_nxt     = seq_inc;
            hdr_syn_nxt = (it.kind == sawq_pkg::KIND_OPEN);
            hdr_fin_nxt = (it.kind == sawq_pkg::KIND_CLOSE);
            hdr_seq_nxt = seq_inc;
            hdr_len_nxt = (it.kind == sawq_pkg::KIND_SEND) ? it.segment_length : 11'd0;
            timer_nxt   = '0;
            res         = mk_hdr(hdr_syn_nxt, hdr_fin_nxt, seq_inc, hdr_len_nxt);
            case (it.kind)
              sawq_pkg::KIND_OPEN: begin
                retry_nxt = '0;
                phase_nxt = sawq_pkg::PH_SYN_SENT;
              end
              sawq_pkg::KIND_SEND: phase_nxt = sawq_pkg::PH_DATA_WAIT;
              default:             phase_nxt = sawq_pkg::PH_FIN_SENT;
            endcase
          end else begin
            res.status = sawq_pkg::StRejected;
          end
        end
        sawq_pkg::KIND_REJECT: res.status = sawq_pkg::StRejected;
        default: ;
      endcase
    end
    if (cfg.we) begin
      case (cfg.index)
        sawq_pkg::CfgTimeout:    timeout_nxt   = cfg.data[19:0];
        sawq_pkg::CfgMaxRetries: retry_cap_nxt = cfg.data[3:0];
        sawq_pkg::CfgInitSeq:    seq_nxt       = cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sawq_pkg::PH_CLOSED;
      seq_r       <= sawq_pkg::InitSeqReset;
      hdr_syn_r   <= 1'b0;
      hdr_fin_r   <= 1'b0;
      hdr_seq_r   <= '0;
      hdr_len_r   <= '0;
      peer_r      <= '0;
      timer_r     <= '0;
      retry_r     <= '0;
      timeout_r   <= sawq_pkg::TimeoutReset;
      retry_cap_r <= sawq_pkg::MaxRetriesReset;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      seq_r       <= seq_nxt;
      hdr_syn_r   <= hdr_syn_nxt;
      hdr_fin_r   <= hdr_fin_nxt;
      hdr_seq_r   <= hdr_seq_nxt;
      hdr_len_r   <= hdr_len_nxt;
      peer_r      <= peer_nxt;
      timer_r     <= timer_nxt;
      retry_r     <= retry_nxt;
      timeout_r   <= timeout_nxt;
      retry_cap_r <= retry_cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.tx_valid      = out_r.tx_valid;
  assign out_chan.tx_syn        = out_r.tx_syn;
  assign out_chan.tx_ackflag    = out_r.tx_ackflag;
  assign out_chan.tx_fin        = out_r.tx_fin;
  assign out_chan.tx_sequence   = out_r.tx_sequence;
  assign out_chan.tx_ack_number = out_r.tx_ack_number;
  assign out_chan.tx_length     = out_r.tx_length;
  assign out_chan.status        = out_r.status;

endmodule

/* rtl/stop_and_wait_arq_sender.sv */
// Stop-and-wait ARQ sender, top level.
// Usage:
//   in_chan carries one event word per handshake: a time tick, a received
//   segment header (flags, numbers, checksum flag) or a host command (open,
//   send one data segment, close). out_chan returns exactly one word per
//   event: a segment header to transmit (tx_valid) and a status code.
//   cfg_we/cfg_index/cfg_wdata write timeout_ticks (0), the SYN retry cap (1)
//   and initial_sequence (2); write only while no event is in flight.
// Timing:
//   An accepted event is written into the queue, then popped from its head into
//   the registered result word on out_chan. One event per cycle is sustained
//   while out_chan.ready holds, fed from a short queue behind the input.
// Reset (rst_n low, synchronous): queue empty, link closed, timeout 1000,
//   retry cap 3, sequence counter 0.
// Receiver stall: the result word holds; the queue keeps accepting events
//   until full, then in_chan.ready drops.
// Depends on sawq_pkg, sawq_in_if, sawq_out_if, sawq_front and sawq_back.
module stop_and_wait_arq_sender #(
  parameter int unsigned QUEUE_DEPTH = sawq_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  sawq_in_if.sink     in_chan,
  sawq_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  sawq_pkg::head_t   head;
  sawq_pkg::cfg_wr_t cfg;
  logic              pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  sawq_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head    (head),
    .pop     (pop)
  );

  sawq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !pop)
    else $error("result word overwritten while stalled");

  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> head.valid)
    else $error("accepted word missing from queue");

  a_fail_sends_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == sawq_pkg::StFailed ||
                        out_chan.status == sawq_pkg::StRejected)) |-> !out_chan.tx_valid)
    else $error("header sent with failed or rejected status");

  a_idle_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.tx_valid) |->
      (out_chan.tx_sequence == 32'd0 && out_chan.tx_ack_number == 32'd0 &&
       out_chan.tx_length == 11'd0 && !out_chan.tx_syn && !out_chan.tx_fin))
    else $error("header fields not cleared");
`endif

endmodule

/* sim/tb.sv */
// Testbench for stop_and_wait_arq_sender: directed and random event words with
// an in-line predictor of the link state, checked word by word on the result side.
// Depends on sawq_pkg, sawq_in_if, sawq_out_if and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ActSpare = 3'd7;
  localparam int LongHold   = 64;
  localparam int StuckLimit = 1000;
  localparam int RoundWords = 230;

  typedef struct packed {
    logic [2:0]  action;
    logic        syn;
    logic        ackf;
    logic        fin;
    logic [31:0] seq;
    logic [31:0] ackno;
    logic        chk;
    logic [10:0] len;
  } seg_event_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  sawq_in_if  in_ch ();
  sawq_out_if out_ch ();

  stop_and_wait_arq_sender i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // link state as the block should hold it
  sawq_pkg::phase_t link_phase   = sawq_pkg::PH_CLOSED;
  logic [19:0]      tmo_limit    = sawq_pkg::TimeoutReset;
  logic [3:0]       retry_limit  = sawq_pkg::MaxRetriesReset;
  logic [31:0]      seq_counter  = sawq_pkg::InitSeqReset;
  logic             hdr_syn      = 1'b0;
  logic             hdr_fin      = 1'b0;
  logic [31:0]      hdr_seq      = '0;
  logic [10:0]      hdr_len      = '0;
  logic [31:0]      peer_seq     = '0;
  logic [19:0]      wait_ticks   = '0;
  logic [3:0]       retries_used = '0;

  sawq_pkg::result_t awaited_words[$];
  int      fail_count  = 0;
  int      stuck_cycles = 0;
  bit      src_gaps  = 1'b1;
  bit      sink_gaps = 1'b1;
  bit      hold_req  = 1'b0;

  function automatic sawq_pkg::result_t header_word(logic syn, logic ackf, logic fin,
                                                    logic [31:0] seq, logic [31:0] ackno,
                                                    logic [10:0] len);
    sawq_pkg::result_t w;
    w = '0;
    w.tx_valid      = 1'b1;
    w.tx_syn        = syn;
    w.tx_ackflag    = ackf;
    w.tx_fin        = fin;
    w.tx_sequence   = seq;
    w.tx_ack_number = ackno;
    w.tx_length     = len;
    return w;
  endfunction

  function automatic sawq_pkg::result_t outstanding_word();
    return header_word(hdr_syn, 1'b0, hdr_fin, hdr_seq,
                       (!hdr_syn && !hdr_fin) ? hdr_seq - 32'd1 : 32'd0, hdr_len);
  endfunction

  function automatic void arm_header(logic syn, logic fin, logic [10:0] len);
    seq_counter = seq_counter + 32'd1;
    hdr_syn     = syn;
    hdr_fin     = fin;
    hdr_seq     = seq_counter;
    hdr_len     = len;
    wait_ticks  = '0;
  endfunction

  function automatic sawq_pkg::result_t step_link(seg_event_t ev);
    sawq_pkg::result_t w;
    logic [2:0]        st;
    logic              acked;
    w     = '0;
    st    = sawq_pkg::StNone;
    acked = ev.ackf && ev.chk && (ev.ackno == hdr_seq + 32'd1);
    case (ev.action)
      sawq_pkg::ActTick: begin
        if (link_phase inside {sawq_pkg::PH_SYN_SENT, sawq_pkg::PH_DATA_WAIT,
                               sawq_pkg::PH_FIN_SENT}) begin
          wait_ticks = wait_ticks + 20'd1;
          if (wait_ticks >= tmo_limit) begin
            wait_ticks = '0;
            if (link_phase == sawq_pkg::PH_SYN_SENT) begin
              retries_used = retries_used + 4'd1;
              if (retries_used >= retry_limit) begin
                link_phase = sawq_pkg::PH_CLOSED;
                st = sawq_pkg::StFailed;
              end else begin
                w = outstanding_word();
              end
            end else begin
              w = outstanding_word();
            end
          end
        end
      end
      sawq_pkg::ActRx: begin
        case (link_phase)
          sawq_pkg::PH_SYN_SENT: begin
            if (ev.syn && acked) begin
              seq_counter = seq_counter + 32'd1;
              peer_seq    = ev.seq;
              w = header_word(1'b0, 1'b1, 1'b0, seq_counter, ev.seq + 32'd1, '0);
              link_phase = sawq_pkg::PH_OPEN;
              st = sawq_pkg::StConnected;
            end else begin
              wait_ticks = '0;
              w = outstanding_word();
            end
          end
          sawq_pkg::PH_DATA_WAIT: begin
            link_phase = acked ? sawq_pkg::PH_OPEN : sawq_pkg::PH_CLOSED;
            st = acked ? sawq_pkg::StAcked : sawq_pkg::StFailed;
          end
          sawq_pkg::PH_FIN_SENT: begin
            if (acked) begin
              peer_seq   = ev.seq;
              link_phase = sawq_pkg::PH_FIN_WAIT;
            end else begin
              link_phase = sawq_pkg::PH_CLOSED;
              st = sawq_pkg::StFailed;
            end
          end
          sawq_pkg::PH_FIN_WAIT: begin
            if (ev.fin && ev.chk && ev.seq == peer_seq + 32'd1) begin
              seq_counter = seq_counter + 32'd1;
              w = header_word(1'b0, 1'b1, 1'b0, seq_counter, ev.seq + 32'd1, '0);
              st = sawq_pkg::StClosed;
            end else begin
              st = sawq_pkg::StFailed;
            end
            link_phase = sawq_pkg::PH_CLOSED;
          end
          default: ;
        endcase
      end
      sawq_pkg::ActOpen: begin
        if (link_phase == sawq_pkg::PH_CLOSED) begin
          arm_header(1'b1, 1'b0, '0);
          retries_used = '0;
          link_phase = sawq_pkg::PH_SYN_SENT;
          w = outstanding_word();
        end else begin
          st = sawq_pkg::StRejected;
        end
      end
      sawq_pkg::ActSend: begin
        if (link_phase == sawq_pkg::PH_OPEN && ev.len <= sawq_pkg::MaxSegBytes) begin
          arm_header(1'b0, 1'b0, ev.len);
          link_phase = sawq_pkg::PH_DATA_WAIT;
          w = outstanding_word();
        end else begin
          st = sawq_pkg::StRejected;
        end
      end
      sawq_pkg::ActClose: begin
        if (link_phase == sawq_pkg::PH_OPEN) begin
          arm_header(1'b0, 1'b1, '0);
          link_phase = sawq_pkg::PH_FIN_SENT;
          w = outstanding_word();
        end else begin
          st = sawq_pkg::StRejected;
        end
      end
      default: ;
    endcase
    w.status = st;
    return w;
  endfunction

  function automatic string word_str(sawq_pkg::result_t w);
    return $sformatf("v=%0d syn=%0d ack=%0d fin=%0d seq=%08h ackno=%08h len=%0d st=%0d",
                     w.tx_valid, w.tx_syn, w.tx_ackflag, w.tx_fin, w.tx_sequence,
                     w.tx_ack_number, w.tx_length, w.status);
  endfunction

  function automatic seg_event_t make_cmd(logic [2:0] act, logic [10:0] len);
    seg_event_t ev;
    ev = '0;
    ev.action = act;
    ev.len    = len;
    return ev;
  endfunction

  function automatic seg_event_t make_rx(logic syn, logic ackf, logic fin, logic [31:0] seq,
                                         logic [31:0] ackno, logic chk);
    seg_event_t ev;
    ev = '0;
    ev.action = sawq_pkg::ActRx;
    ev.syn    = syn;
    ev.ackf   = ackf;
    ev.fin    = fin;
    ev.seq    = seq;
    ev.ackno  = ackno;
    ev.chk    = chk;
    return ev;
  endfunction

  function automatic seg_event_t noise_word();
    seg_event_t ev;
    ev.action = 3'($urandom_range(0, 7));
    ev.syn    = 1'($urandom_range(0, 1));
    ev.ackf   = 1'($urandom_range(0, 1));
    ev.fin    = 1'($urandom_range(0, 1));
    ev.seq    = $urandom;
    ev.ackno  = $urandom;
    ev.chk    = 1'($urandom_range(0, 1));
    ev.len    = 11'($urandom_range(0, 2047));
    return ev;
  endfunction

  // one required part of a good reply is broken
  function automatic seg_event_t spoil(seg_event_t ev);
    logic [31:0] m;
    m = 32'($urandom_range(1, 32'hFFFF_FFFF));
    case ($urandom_range(0, 2))
      0: ev.chk = 1'b0;
      1: begin
        ev.syn  = 1'b0;
        ev.ackf = 1'b0;
        ev.fin  = 1'b0;
      end
      default: begin
        ev.ackno = ev.ackno ^ m;
        ev.seq   = ev.seq ^ m;
      end
    endcase
    return ev;
  endfunction

  // mostly the well-formed next step of the link, with random content
  function automatic seg_event_t next_event();
    seg_event_t ev;
    int         roll;
    bit         waiting;
    ev      = noise_word();
    roll    = $urandom_range(0, 99);
    waiting = (link_phase != sawq_pkg::PH_CLOSED && link_phase != sawq_pkg::PH_OPEN);
    if (waiting && roll < 60) begin
      ev.action = sawq_pkg::ActRx;
      ev.chk    = 1'b1;
      ev.ackf   = 1'b1;
      ev.ackno  = hdr_seq + 32'd1;
      if (link_phase == sawq_pkg::PH_SYN_SENT) ev.syn = 1'b1;
      if (link_phase == sawq_pkg::PH_FIN_WAIT) begin
        ev.fin = 1'b1;
        ev.seq = peer_seq + 32'd1;
      end
      if (roll >= 48) ev = spoil(ev);
    end else if (waiting && roll < 88) begin
      ev.action = sawq_pkg::ActTick;
    end else if (link_phase == sawq_pkg::PH_CLOSED && roll < 80) begin
      ev.action = sawq_pkg::ActOpen;
    end else if (link_phase == sawq_pkg::PH_OPEN && roll < 60) begin
      ev.action = sawq_pkg::ActSend;
      ev.len = (roll < 54) ? 11'($urandom_range(0, sawq_pkg::MaxSegBytes))
                           : 11'($urandom_range(sawq_pkg::MaxSegBytes + 1, 2047));
    end else if (link_phase == sawq_pkg::PH_OPEN && roll < 72) begin
      ev.action = sawq_pkg::ActClose;
    end
    return ev;
  endfunction

  task automatic send_event(seg_event_t ev);
    int gap;
    gap = (src_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= ev.action;
    in_ch.rx_syn         <= ev.syn;
    in_ch.rx_ackflag     <= ev.ackf;
    in_ch.rx_fin         <= ev.fin;
    in_ch.rx_sequence    <= ev.seq;
    in_ch.rx_ack_number  <= ev.ackno;
    in_ch.rx_checksum_ok <= ev.chk;
    in_ch.segment_length <= ev.len;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    awaited_words.push_back(step_link(ev));
  endtask

  task automatic drain_link();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sawq_pkg::CfgTimeout:    tmo_limit = val[19:0];
      sawq_pkg::CfgMaxRetries: retry_limit = val[3:0];
      sawq_pkg::CfgInitSeq:    seq_counter = val;
      default: ;
    endcase
  endtask

  task automatic test_idle_phases();
    send_event(make_cmd(sawq_pkg::ActTick, '0));
    send_event(make_rx(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1));
    send_event(make_cmd(sawq_pkg::ActSend, 11'd1));
    send_event(make_cmd(sawq_pkg::ActClose, '0));
    send_event(make_cmd(ActSpare, 11'd2047));
  endtask

  task automatic test_handshake();
    send_event(make_cmd(sawq_pkg::ActOpen, '0));
    send_event(make_cmd(sawq_pkg::ActOpen, '0));
    send_event(make_rx(1'b1, 1'b1, 1'b0, 32'h1234_5678, hdr_seq + 32'd1, 1'b0));
    send_event(make_rx(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, hdr_seq + 32'd1, 1'b1));
    send_event(make_cmd(sawq_pkg::ActSend, 11'd1024));
    send_event(make_cmd(sawq_pkg::ActSend, 11'd5));
    send_event(make_rx(1'b0, 1'b1, 1'b0, 32'h0, hdr_seq + 32'd1, 1'b1));
    send_event(make_cmd(sawq_pkg::ActSend, 11'd2047));
    send_event(make_cmd(sawq_pkg::ActSend, 11'd0));
    send_event(make_rx(1'b0, 1'b1, 1'b0, 32'h0, hdr_seq + 32'd2, 1'b1));
  endtask

  task automatic test_close();
    send_event(make_cmd(sawq_pkg::ActOpen, '0));
    send_event(make_rx(1'b1, 1'b1, 1'b0, 32'h0000_0000, hdr_seq + 32'd1, 1'b1));
    send_event(make_cmd(sawq_pkg::ActClose, '0));
    send_event(make_rx(1'b0, 1'b1, 1'b0, 32'h8000_0000, hdr_seq + 32'd1, 1'b1));
    send_event(make_rx(1'b0, 1'b0, 1'b1, peer_seq + 32'd1, 32'h0, 1'b1));
  endtask

  // zero timeout resends on every tick; zero retries fails at the first timeout
  task automatic test_timeouts();
    drain_link();
    write_reg(sawq_pkg::CfgTimeout, 32'd0);
    write_reg(sawq_pkg::CfgMaxRetries, 32'd0);
    write_reg(sawq_pkg::CfgInitSeq, 32'hFFFF_FFFF);
    send_event(make_cmd(sawq_pkg::ActOpen, '0));
    send_event(make_cmd(sawq_pkg::ActTick, '0));
    drain_link();
    write_reg(sawq_pkg::CfgMaxRetries, 32'd15);
    send_event(make_cmd(sawq_pkg::ActOpen, '0));
    send_event(make_cmd(sawq_pkg::ActTick, '0));
    send_event(make_cmd(sawq_pkg::ActTick, '0));
    send_event(make_rx(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFE, hdr_seq + 32'd1, 1'b1));
  endtask

  task automatic test_backpressure();
    int k;
    drain_link();
    write_reg(sawq_pkg::CfgTimeout, 32'd2);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    for (k = 0; k < 16; k++) send_event(next_event());
    src_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int         round;
    int         counted;
    bit         ignored;
    seg_event_t ev;
    for (round = 0; round < 6; round++) begin
      drain_link();
      case (round)
        0: begin
          write_reg(sawq_pkg::CfgTimeout, 32'd1);
          write_reg(sawq_pkg::CfgMaxRetries, 32'd1);
          write_reg(sawq_pkg::CfgInitSeq, $urandom);
        end
        1: begin
          write_reg(sawq_pkg::CfgTimeout, 32'($urandom_range(2, 6)));
          write_reg(sawq_pkg::CfgMaxRetries, 32'd15);
          write_reg(sawq_pkg::CfgInitSeq, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(sawq_pkg::CfgTimeout, 32'd1048575);
          write_reg(sawq_pkg::CfgMaxRetries, 32'($urandom_range(1, 15)));
          write_reg(sawq_pkg::CfgInitSeq, 32'd0);
        end
        default: begin
          write_reg(sawq_pkg::CfgTimeout, 32'($urandom_range(1, 8)));
          write_reg(sawq_pkg::CfgMaxRetries, 32'($urandom_range(1, 4)));
          write_reg(sawq_pkg::CfgInitSeq, $urandom);
        end
      endcase
      src_gaps  = (round != 3 && round != 5);
      sink_gaps = (round != 3 && round != 5);
      counted = 0;
      while (counted < RoundWords) begin
        ev = next_event();
        ignored = (ev.action > sawq_pkg::ActClose) ||
                  ((ev.action == sawq_pkg::ActTick || ev.action == sawq_pkg::ActRx) &&
                   (link_phase == sawq_pkg::PH_CLOSED || link_phase == sawq_pkg::PH_OPEN));
        send_event(ev);
        if (!ignored) counted++;
      end
    end
  endtask

  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    sawq_pkg::result_t got;
    sawq_pkg::result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.tx_valid, out_ch.tx_syn, out_ch.tx_ackflag, out_ch.tx_fin,
             out_ch.tx_sequence, out_ch.tx_ack_number, out_ch.tx_length, out_ch.status};
      if (awaited_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected word: %s", word_str(got));
      end else begin
        want = awaited_words.pop_front();
        if (got.tx_valid !== want.tx_valid || got.tx_syn !== want.tx_syn ||
            got.tx_ackflag !== want.tx_ackflag || got.tx_fin !== want.tx_fin ||
            got.tx_sequence !== want.tx_sequence ||
            got.tx_ack_number !== want.tx_ack_number ||
            got.tx_length !== want.tx_length || got.status !== want.status) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t: expected %s", $realtime, word_str(want));
            $display("                got      %s", word_str(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("timeout: no word moved for %0d cycles", StuckLimit);
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : run
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.action         = '0;
    in_ch.rx_syn         = 1'b0;
    in_ch.rx_ackflag     = 1'b0;
    in_ch.rx_fin         = 1'b0;
    in_ch.rx_sequence    = '0;
    in_ch.rx_ack_number  = '0;
    in_ch.rx_checksum_ok = 1'b0;
    in_ch.segment_length = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_phases();
    test_handshake();
    test_close();
    test_timeouts();
    test_backpressure();
    test_random_traffic();
    drain_link();
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
